// ----- sv/gated_square_matrix_multiply_top_macros.svh -----
// assertion macros for the gated square matrix multiply block
// used by gated_square_matrix_multiply_top.sv, no other dependencies
`ifndef GATED_SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define GATED_SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH

`ifndef SYNTHESIS
// expression holds on every clock edge out of reset
`define GSMM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent implies consequent on the next clock edge
`define GSMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GSMM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define GSMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/gsmm_pkg.sv -----
// types, constants and microcode table of the gated square matrix multiply block
// no dependencies; used by gsmm_seq and gated_square_matrix_multiply_top
`timescale 1ns / 1ps
`default_nettype none

package gsmm_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int RES_W  = 33;
    localparam int SIZE_W = 4;
    localparam int STEP_W = 3;

    // microcode step addresses
    localparam logic [STEP_W-1:0] STEP_LOAD      = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ISSUE     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN_MUL = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DRAIN_ACC = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_REJECT    = 3'd5;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_LOAD,
        JMP_KLOOP,
        JMP_EMIT,
        JMP_REJECT
    } jump_t;

    typedef struct packed {
        logic              in_ready;
        logic              rd_issue;
        logic              out_load;
        logic              out_reject;
        jump_t             jump;
        logic [STEP_W-1:0] target;
        logic [STEP_W-1:0] alt;
    } ctrl_word_t;

    typedef struct packed {
        logic in_accept;
        logic load_final;
        logic pos_next;
        logic k_last;
        logic out_free;
        logic entry_last;
    } status_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] first_element;
        logic signed [ELEM_W-1:0] second_element;
    } in_word_t;

    typedef struct packed {
        logic [RES_W-1:0] product_element;
        logic             all_positive;
        logic             last_result;
    } out_word_t;

    function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w        = '0;
        w.jump   = JMP_NEXT;
        w.target = STEP_LOAD;
        w.alt    = STEP_LOAD;
        unique case (step)
            STEP_LOAD:
            begin
                w.in_ready = 1'b1;
                w.jump     = JMP_LOAD;
                w.target   = STEP_LOAD;
                w.alt      = STEP_REJECT;
            end
            STEP_ISSUE:
            begin
                w.rd_issue = 1'b1;
                w.jump     = JMP_KLOOP;
            end
            STEP_DRAIN_MUL:
            begin
                w.jump = JMP_NEXT;
            end
            STEP_DRAIN_ACC:
            begin
                w.jump = JMP_NEXT;
            end
            STEP_EMIT:
            begin
                w.out_load = 1'b1;
                w.jump     = JMP_EMIT;
                w.target   = STEP_LOAD;
                w.alt      = STEP_ISSUE;
            end
            STEP_REJECT:
            begin
                w.out_reject = 1'b1;
                w.jump       = JMP_REJECT;
                w.target     = STEP_LOAD;
            end
            default:
            begin
                w.jump   = JMP_GOTO;
                w.target = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gsmm_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gsmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/gsmm_seq.sv -----
// microcode sequencer: step counter, control table lookup and jumps
// depends on gsmm_pkg
`timescale 1ns / 1ps
`default_nettype none

module gsmm_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gsmm_pkg::status_t    status,
    output      gsmm_pkg::ctrl_word_t ctrl
);

    logic [gsmm_pkg::STEP_W-1:0] pc_reg;
    logic [gsmm_pkg::STEP_W-1:0] pc_next;

    assign ctrl = gsmm_pkg::rom_word(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= gsmm_pkg::STEP_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        pc_next = pc_reg;
        unique case (ctrl.jump)
            gsmm_pkg::JMP_NEXT:
            begin
                pc_next = pc_reg + gsmm_pkg::STEP_W'(1);
            end
            gsmm_pkg::JMP_GOTO:
            begin
                pc_next = ctrl.target;
            end
            gsmm_pkg::JMP_LOAD:
            begin
                priority if (!status.in_accept)
                    pc_next = pc_reg;
                else if (!status.load_final)
                    pc_next = ctrl.target;
                else if (!status.pos_next)
                    pc_next = ctrl.alt;
                else
                    pc_next = pc_reg + gsmm_pkg::STEP_W'(1);
            end
            gsmm_pkg::JMP_KLOOP:
            begin
                pc_next = status.k_last ? pc_reg + gsmm_pkg::STEP_W'(1) : pc_reg;
            end
            gsmm_pkg::JMP_EMIT:
            begin
                priority if (!status.out_free)
                    pc_next = pc_reg;
                else if (status.entry_last)
                    pc_next = ctrl.target;
                else
                    pc_next = ctrl.alt;
            end
            gsmm_pkg::JMP_REJECT:
            begin
                pc_next = status.out_free ? ctrl.target : pc_reg;
            end
            default:
            begin
                pc_next = gsmm_pkg::STEP_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/gated_square_matrix_multiply_top.sv -----
// gated square matrix multiply: top level with datapath and stores
// depends on gsmm_pkg, gsmm_seq, gsmm_ram and the assertion macro header
//
// channel  dir  handshake                word
// in       in   in_valid / in_ready      first_element, second_element
// out      out  out_valid / out_ready    product_element, all_positive, last_result
// cfg      in   cfg_wr_en                matrix_size (cfg_wr_data)
//
// loading accepts words back to back while in the load step; each product entry
// issues n reads through the one read port of each store into the shared multiply
// and accumulate, then passes through the drain_mul, drain_acc and emit steps.
// a rejected run gives its single word from the reject step once the output is free.
// reset clears the control state and the accumulator; the stores need no clearing pass.
// a stalled output holds the emit step; the next run loads while the last word waits.
`timescale 1ns / 1ps
`default_nettype none
`include "gated_square_matrix_multiply_top_macros.svh"

module gated_square_matrix_multiply_top #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gsmm_pkg::SIZE_W-1:0]   cfg_wr_data,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire gsmm_pkg::in_word_t            in_data,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      gsmm_pkg::out_word_t           out_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EW    = gsmm_pkg::ELEM_W;

    gsmm_pkg::ctrl_word_t ctrl;
    gsmm_pkg::status_t    status;

    logic [gsmm_pkg::SIZE_W-1:0] size_reg;
    logic [DIM_W-1:0]            eff_n;
    logic [DIM_W-1:0]            n_m1;
    logic [CW-1:0]               n_c;
    logic [CW-1:0]               total_c;
    logic [CW-1:0]               load_count_reg;
    logic                        pos_reg;
    logic                        item_pos;
    logic                        in_accept;

    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic             i_last;
    logic             j_last;
    logic             k_last;
    logic [AW-1:0]    n_w;
    logic [AW-1:0]    a_addr;
    logic [AW-1:0]    b_addr;

    logic [EW-1:0]                   a_rd;
    logic [EW-1:0]                   b_rd;
    logic [gsmm_pkg::PROD_W-1:0]     prod;
    logic [gsmm_pkg::PROD_W-1:0]     prod_reg;
    logic [gsmm_pkg::RES_W-1:0]      acc_reg;
    logic                            rd_v_reg;
    logic                            mul_v_reg;

    logic                 out_free;
    logic                 out_valid_reg;
    gsmm_pkg::out_word_t  out_data_reg;

    // size register with clamping to 1..MAX_DIM
    always_comb
    begin
        priority if (size_reg == '0)
            eff_n = DIM_W'(1);
        else if (size_reg > gsmm_pkg::SIZE_W'(MAX_DIM))
            eff_n = DIM_W'(MAX_DIM);
        else
            eff_n = DIM_W'(size_reg);
    end

    assign n_m1    = eff_n - DIM_W'(1);
    assign n_c     = CW'(eff_n);
    assign total_c = n_c * n_c;
    assign n_w     = AW'(eff_n);

    assign in_ready  = ctrl.in_ready;
    assign in_accept = in_valid & ctrl.in_ready;
    assign item_pos  = !in_data.first_element[EW-1] && (in_data.first_element != '0) &&
                       !in_data.second_element[EW-1] && (in_data.second_element != '0);

    assign i_last = (DIM_W'(i_reg) == n_m1);
    assign j_last = (DIM_W'(j_reg) == n_m1);
    assign k_last = (DIM_W'(k_reg) == n_m1);

    // first store is read along row i, second along column j
    assign a_addr = AW'(i_reg) * n_w + AW'(k_reg);
    assign b_addr = AW'(k_reg) * n_w + AW'(j_reg);

    assign out_free = !out_valid_reg || out_ready;

    assign status.in_accept  = in_accept;
    assign status.load_final = (load_count_reg + CW'(1)) == total_c;
    assign status.pos_next   = pos_reg & item_pos;
    assign status.k_last     = k_last;
    assign status.out_free   = out_free;
    assign status.entry_last = i_last & j_last;

    gsmm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    gsmm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_first_store (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (load_count_reg[AW-1:0]),
        .wr_data (in_data.first_element),
        .rd_en   (ctrl.rd_issue),
        .rd_addr (a_addr),
        .rd_data (a_rd)
    );

    gsmm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_second_store (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (load_count_reg[AW-1:0]),
        .wr_data (in_data.second_element),
        .rd_en   (ctrl.rd_issue),
        .rd_addr (b_addr),
        .rd_data (b_rd)
    );

    // products run only on all-positive runs, so raw bits are unsigned
    assign prod = a_rd * b_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= gsmm_pkg::SIZE_W'(MAX_DIM);
            load_count_reg <= '0;
            pos_reg        <= 1'b1;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rd_v_reg       <= 1'b0;
            mul_v_reg      <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= ctrl.rd_issue;
            mul_v_reg <= rd_v_reg;

            if (cfg_wr_en)
            begin
                size_reg       <= cfg_wr_data;
                load_count_reg <= '0;
                pos_reg        <= 1'b1;
            end
            else if (in_accept)
            begin
                if (status.load_final)
                begin
                    load_count_reg <= '0;
                    pos_reg        <= 1'b1;
                end
                else
                begin
                    load_count_reg <= load_count_reg + CW'(1);
                    pos_reg        <= status.pos_next;
                end
            end

            if (ctrl.rd_issue)
            begin
                k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
            end

            if (ctrl.out_load && out_free)
            begin
                acc_reg <= '0;
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_last ? '0 : i_reg + IDX_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
            else if (mul_v_reg)
            begin
                acc_reg <= acc_reg + gsmm_pkg::RES_W'(prod_reg);
            end

            if ((ctrl.out_load || ctrl.out_reject) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= prod;
        end
        if (ctrl.out_load && out_free)
        begin
            out_data_reg.product_element <= acc_reg;
            out_data_reg.all_positive    <= 1'b1;
            out_data_reg.last_result     <= i_last & j_last;
        end
        else if (ctrl.out_reject && out_free)
        begin
            out_data_reg.product_element <= '0;
            out_data_reg.all_positive    <= 1'b0;
            out_data_reg.last_result     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `GSMM_ASSERT_ALWAYS(a_load_pipe_empty, clk, rst_n, !ctrl.in_ready || (!rd_v_reg && !mul_v_reg), "input taken while the multiply pipeline is busy")
    `GSMM_ASSERT_ALWAYS(a_emit_pipe_empty, clk, rst_n, !ctrl.out_load || (!rd_v_reg && !mul_v_reg), "entry emitted before its sum is complete")
    `GSMM_ASSERT_ALWAYS(a_count_range, clk, rst_n, load_count_reg < total_c, "load count reached the matrix size")
    `GSMM_ASSERT_NEXT(a_issue_next, clk, rst_n, ctrl.rd_issue && k_last, !ctrl.rd_issue && rd_v_reg, "read issue did not stop after the last column")

endmodule

`default_nettype wire

// ----- dv/gated_square_matrix_multiply_top_tb.sv -----
// testbench for gated_square_matrix_multiply_top: directed and random runs of matrix loads
// predicts every product word in a small scoreboard class; depends on gsmm_pkg and the dut
`timescale 1ns / 1ps

localparam int MAX_DIM = 8;

class product_scoreboard;
    logic [gsmm_pkg::ELEM_W-1:0] first_mem [MAX_DIM*MAX_DIM];
    logic [gsmm_pkg::ELEM_W-1:0] second_mem [MAX_DIM*MAX_DIM];
    logic [gsmm_pkg::SIZE_W-1:0] size_code;
    int unsigned                 loaded;
    bit                          all_pos;
    gsmm_pkg::out_word_t         expected_entries [$];
    int unsigned                 errors;

    function new();
        size_code = gsmm_pkg::SIZE_W'(MAX_DIM);
        loaded    = 0;
        all_pos   = 1'b1;
        errors    = 0;
    endfunction

    // zero acts as one, anything past the limit as the limit
    function int unsigned dim_of(input logic [gsmm_pkg::SIZE_W-1:0] code);
        if (code == '0)
            return 1;
        if (code > gsmm_pkg::SIZE_W'(MAX_DIM))
            return MAX_DIM;
        return 32'(code);
    endfunction

    function bit strictly_positive(input logic [gsmm_pkg::ELEM_W-1:0] v);
        return v != '0 && !v[gsmm_pkg::ELEM_W-1];
    endfunction

    // a size write also throws away a partly loaded run
    function void set_size(input logic [gsmm_pkg::SIZE_W-1:0] code);
        size_code = code;
        loaded    = 0;
        all_pos   = 1'b1;
    endfunction

    function int unsigned pending();
        return expected_entries.size();
    endfunction

    function void load_element(input gsmm_pkg::in_word_t w);
        int unsigned         n;
        int unsigned         slot;
        logic [63:0]         acc;
        gsmm_pkg::out_word_t r;
        n    = dim_of(size_code);
        slot = loaded % (MAX_DIM * MAX_DIM);
        first_mem[slot]  = w.first_element;
        second_mem[slot] = w.second_element;
        if (!strictly_positive(w.first_element) || !strictly_positive(w.second_element))
            all_pos = 1'b0;
        loaded = slot + 1;
        if (loaded < n * n)
            return;
        if (!all_pos)
        begin
            r.product_element = '0;
            r.all_positive    = 1'b0;
            r.last_result     = 1'b1;
            expected_entries.push_back(r);
        end
        else
        begin
            for (int unsigned i = 0; i < n; i++)
            begin
                for (int unsigned j = 0; j < n; j++)
                begin
                    acc = '0;
                    for (int unsigned k = 0; k < n; k++)
                        acc = acc + 64'(first_mem[i*n + k]) * 64'(second_mem[k*n + j]);
                    r.product_element = acc[gsmm_pkg::RES_W-1:0];
                    r.all_positive    = 1'b1;
                    r.last_result     = (i == n - 1) && (j == n - 1);
                    expected_entries.push_back(r);
                end
            end
        end
        loaded  = 0;
        all_pos = 1'b1;
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    task check_entry(input gsmm_pkg::out_word_t got);
        gsmm_pkg::out_word_t want;
        if (expected_entries.size() == 0)
        begin
            report_mismatch("unexpected word", 64'(got), 64'd0);
            return;
        end
        want = expected_entries.pop_front();
        if (got.product_element !== want.product_element)
            report_mismatch("product_element", 64'(got.product_element),
                            64'(want.product_element));
        if (got.all_positive !== want.all_positive)
            report_mismatch("all_positive", 64'(got.all_positive), 64'(want.all_positive));
        if (got.last_result !== want.last_result)
            report_mismatch("last_result", 64'(got.last_result), 64'(want.last_result));
    endtask
endclass

module gated_square_matrix_multiply_top_tb;

    localparam int DRAIN_CYCLES = MAX_DIM * MAX_DIM * (MAX_DIM + 3);
    localparam int WATCH_LIMIT  = 4000;
    localparam logic [gsmm_pkg::ELEM_W-1:0] ELEM_MAX = 16'h7FFF;
    localparam logic [gsmm_pkg::ELEM_W-1:0] ELEM_MIN = 16'h8000;
    localparam logic [gsmm_pkg::ELEM_W-1:0] ELEM_NEG_ONE = 16'hFFFF;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [gsmm_pkg::SIZE_W-1:0] cfg_wr_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    gsmm_pkg::in_word_t          in_data = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    gsmm_pkg::out_word_t         out_data;

    product_scoreboard  sb = new();
    gsmm_pkg::in_word_t word_q [$];
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct = 0;
    int unsigned        hold_cycles = 0;
    int unsigned        quiet;

    gated_square_matrix_multiply_top #(
        .MAX_DIM     (MAX_DIM)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: a long hold-off wins over the random stall
    always @(negedge clk)
    begin
        if (hold_cycles != 0)
        begin
            out_ready   = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.load_element(in_data);
            if (out_valid && out_ready)
                sb.check_entry(out_data);
        end
    end

    function automatic gsmm_pkg::in_word_t pair(input logic [gsmm_pkg::ELEM_W-1:0] a,
                                                input logic [gsmm_pkg::ELEM_W-1:0] b);
        gsmm_pkg::in_word_t w;
        w.first_element  = a;
        w.second_element = b;
        return w;
    endfunction

    function automatic logic [gsmm_pkg::ELEM_W-1:0] pick_positive();
        case ($urandom_range(9))
            0:       return 16'h0001;
            1:       return ELEM_MAX;
            default: return gsmm_pkg::ELEM_W'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [gsmm_pkg::ELEM_W-1:0] pick_nonpositive();
        case ($urandom_range(4))
            0:       return '0;
            1:       return ELEM_MIN;
            2:       return ELEM_NEG_ONE;
            default: return {1'b1, 15'($urandom)};
        endcase
    endfunction

    // one run of n*n words, all positive unless spoiled
    function automatic void queue_run(input int unsigned n, input bit spoil);
        gsmm_pkg::in_word_t run_words [$];
        int unsigned        pos;
        for (int unsigned e = 0; e < n * n; e++)
        begin
            if (spoil && $urandom_range(3) == 0)
                run_words.push_back(pair(gsmm_pkg::ELEM_W'($urandom),
                                         gsmm_pkg::ELEM_W'($urandom)));
            else
                run_words.push_back(pair(pick_positive(), pick_positive()));
        end
        if (spoil)
        begin
            repeat ($urandom_range(1, 3))
            begin
                pos = $urandom_range(n * n - 1);
                case ($urandom_range(2))
                    0:       run_words[pos].first_element = pick_nonpositive();
                    1:       run_words[pos].second_element = pick_nonpositive();
                    default: run_words[pos] = pair(pick_nonpositive(), pick_nonpositive());
                endcase
            end
        end
        foreach (run_words[e])
            word_q.push_back(run_words[e]);
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input gsmm_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_data  = w;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_queued();
        while (word_q.size() != 0)
            send_word(word_q.pop_front());
        in_valid = 1'b0;
    endtask

    // hold the input until every expected word is out, then let the block drain
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_size(input logic [gsmm_pkg::SIZE_W-1:0] code);
        @(negedge clk);
        cfg_wr_data = code;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.set_size(code);
    endtask

    task automatic run_phase(input logic [gsmm_pkg::SIZE_W-1:0] code, input int unsigned runs,
                             input int unsigned spoil_pct, input int unsigned idle_pct,
                             input int unsigned stall);
        int unsigned n;
        settle();
        write_size(code);
        n             = sb.dim_of(code);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (runs)
            queue_run(n, $urandom_range(99) < spoil_pct);
        send_queued();
    endtask

    initial
    begin
        quiet = 0;
        while (quiet < WATCH_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[gated_square_matrix_multiply_top] ERROR");
        $finish;
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one by one: extremes and every way to be non-positive
        write_size(4'd1);
        word_q.push_back(pair(ELEM_MAX, ELEM_MAX));
        word_q.push_back(pair(16'h0001, 16'h0001));
        word_q.push_back(pair(ELEM_MIN, 16'h0005));
        word_q.push_back(pair(16'h0000, 16'h0007));
        word_q.push_back(pair(16'h0007, 16'h0000));
        word_q.push_back(pair(ELEM_NEG_ONE, ELEM_NEG_ONE));
        word_q.push_back(pair(ELEM_MAX, ELEM_MIN));
        word_q.push_back(pair(16'h3039, 16'h0002));
        send_queued();

        // size code zero behaves as one
        settle();
        write_size(4'd0);
        word_q.push_back(pair(16'h0003, 16'h0004));
        word_q.push_back(pair(ELEM_MAX, 16'h0001));
        send_queued();

        // 2x2 at full scale, then a run spoiled on its final word, then a partial run
        settle();
        write_size(4'd2);
        repeat (4)
            word_q.push_back(pair(ELEM_MAX, ELEM_MAX));
        repeat (3)
            word_q.push_back(pair(16'h0002, 16'h0003));
        word_q.push_back(pair(16'h0005, ELEM_NEG_ONE));
        word_q.push_back(pair(16'h0003, 16'h0003));
        word_q.push_back(pair(16'h0004, 16'h0004));
        send_queued();

        // random runs; the size write at the start of the first drops the partial run
        run_phase(4'd3, 2, 20, 0, 0);
        run_phase(4'd2, 8, 25, 79, 0);
        run_phase(4'd5, 1, 20, 0, 79);

        // over-range code acts as the largest size; all-max run gives the widest sum
        settle();
        write_size(4'd15);
        send_idle_pct = 29;
        stall_pct     = 29;
        repeat (MAX_DIM * MAX_DIM)
            word_q.push_back(pair(ELEM_MAX, ELEM_MAX));
        send_queued();

        // receiver holds off while the sender keeps offering, so the input backs up
        settle();
        write_size(4'd2);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge clk);
        hold_cycles = 400;
        @(negedge clk);
        repeat (4)
            queue_run(2, 1'b0);
        send_queued();

        run_phase(4'd1, 10, 30, 0, 79);
        run_phase(4'd4, 2, 30, 29, 29);

        settle();
        if (sb.errors == 0)
            $display("[gated_square_matrix_multiply_top] OK");
        else
            $display("[gated_square_matrix_multiply_top] ERROR");
        $finish;
    end

endmodule
